@@ rtl/scd_pkg.sv @@
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types, codes and commutation tables for the six-step duty block.
// ----------------------------------------------------------------------------
package scd_pkg;

   // field widths
   localparam int VOLT_WIDTH   = 16;
   localparam int INV_WIDTH    = 16;
   localparam int DUTY_WIDTH   = 16;
   localparam int HALL_WIDTH   = 3;
   localparam int MODE_WIDTH   = 2;
   localparam int PAIR_WIDTH   = 3;
   localparam int PROD_WIDTH   = 32;   // Q8.24 signed product
   localparam int PROD_FRAC    = 24;
   localparam int NUM_SECTORS  = 6;

   // register map
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_DUTY = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_DUTY = 1'b1;
   localparam logic [CSR_DATA_WIDTH-1:0]  MAX_DUTY_RESET = 16'd32768;
   localparam logic [CSR_DATA_WIDTH-1:0]  MIN_DUTY_RESET = 16'd0;

   // pwm mode codes
   localparam logic [MODE_WIDTH-1:0] MODE_UV_W_OFF = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_U_OFF_VW = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_UW_V_OFF = 2'd2;

   // phase pair codes
   localparam logic [PAIR_WIDTH-1:0] PAIR_UH_VL = 3'd0;
   localparam logic [PAIR_WIDTH-1:0] PAIR_UH_WL = 3'd1;
   localparam logic [PAIR_WIDTH-1:0] PAIR_VH_WL = 3'd2;
   localparam logic [PAIR_WIDTH-1:0] PAIR_VH_UL = 3'd3;
   localparam logic [PAIR_WIDTH-1:0] PAIR_WH_UL = 3'd4;
   localparam logic [PAIR_WIDTH-1:0] PAIR_WH_VL = 3'd5;

   typedef enum logic [1:0] {
      PHASE_U,
      PHASE_V,
      PHASE_W
   } phase_type;

   typedef struct packed {
      logic [PAIR_WIDTH-1:0] pair;
      logic [MODE_WIDTH-1:0] mode;
      phase_type             high;
   } commut_type;

   // phase pair for wrapped sector 1..6, indexed by sector-1
   localparam logic [PAIR_WIDTH-1:0] SECTOR_PAIR [NUM_SECTORS] = '{
      PAIR_WH_VL, PAIR_UH_VL, PAIR_UH_WL, PAIR_VH_WL, PAIR_VH_UL, PAIR_WH_UL
   };

   localparam logic [MODE_WIDTH-1:0] PAIR_MODE [NUM_SECTORS] = '{
      MODE_UV_W_OFF, MODE_UW_V_OFF, MODE_U_OFF_VW,
      MODE_UV_W_OFF, MODE_UW_V_OFF, MODE_U_OFF_VW
   };

   localparam phase_type PAIR_HIGH [NUM_SECTORS] = '{
      PHASE_U, PHASE_U, PHASE_V, PHASE_V, PHASE_W, PHASE_W
   };

endpackage

@@ rtl/scd_duty.sv @@
// ----------------------------------------------------------------------------
// scd_duty
// Scales the Q8.24 product to a saturated duty and applies the max/min clamp.
// ----------------------------------------------------------------------------
module scd_duty #(
   parameter int DUTY_FRAC_BITS = 15
) (
   input  logic signed [scd_pkg::PROD_WIDTH-1:0]     product,
   input  logic        [scd_pkg::CSR_DATA_WIDTH-1:0] max_duty,
   input  logic        [scd_pkg::CSR_DATA_WIDTH-1:0] min_duty,
   output logic        [scd_pkg::DUTY_WIDTH-1:0]     duty
);
   import scd_pkg::*;

   localparam int SHIFT = PROD_FRAC - DUTY_FRAC_BITS;
   localparam logic [PROD_WIDTH-1:0] FULL_SCALE =
      (DUTY_FRAC_BITS >= DUTY_WIDTH) ? PROD_WIDTH'((1 << DUTY_WIDTH) - 1)
                                     : PROD_WIDTH'(1) << DUTY_FRAC_BITS;

   logic [PROD_WIDTH-1:0] scaled;
   logic [DUTY_WIDTH-1:0] sat;

   always_comb begin
      scaled = unsigned'(product) >> SHIFT;
      if (product <= 0) begin
         sat = '0;
      end else if (scaled > FULL_SCALE) begin
         sat = FULL_SCALE[DUTY_WIDTH-1:0];
      end else begin
         sat = scaled[DUTY_WIDTH-1:0];
      end

      // max is checked first: when the two cross, a duty above max gets max, any other gets min
      if (sat > max_duty) begin
         duty = max_duty;
      end else if (sat < min_duty) begin
         duty = min_duty;
      end else begin
         duty = sat;
      end
   end

endmodule

@@ rtl/scd_sector.sv @@
// ----------------------------------------------------------------------------
// scd_sector
// Moves the hall sector forward two or back one, wraps it into 1..6 and looks up the phase pair.
// ----------------------------------------------------------------------------
module scd_sector (
   input  logic [scd_pkg::HALL_WIDTH-1:0] hall_sector,
   input  logic                           torque_positive,
   output scd_pkg::commut_type            commut
);
   import scd_pkg::*;

   logic signed [4:0] sum;
   logic signed [4:0] wrapped;
   logic signed [4:0] index_full;
   logic [2:0]        index;

   always_comb begin
      sum = $signed({2'b00, hall_sector}) + (torque_positive ? 5'sd2 : -5'sd1);
      if (sum > 5'sd6) begin
         wrapped = sum - 5'sd6;
      end else if (sum < 5'sd1) begin
         wrapped = sum + 5'sd6;
      end else begin
         wrapped = sum;
      end
      index_full  = wrapped - 5'sd1;
      index       = index_full[2:0];
      commut.pair = SECTOR_PAIR[index];
      commut.mode = PAIR_MODE[commut.pair];
      commut.high = PAIR_HIGH[commut.pair];
   end

endmodule

@@ rtl/six_step_commutation_duty.sv @@
// ----------------------------------------------------------------------------
// six_step_commutation_duty
// Six-step commutation: voltage command times 1/Vbus gives a clamped duty,
// placed on the high-side phase of the pair selected by the hall sector.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  req_    | in        | req_valid/req_ready  | voltage, 1/Vbus, hall, torque
//  rsp_    | out       | rsp_valid/rsp_ready  | duty_u/v/w, pwm_mode, phase_pair
//  csr_    | in        | csr_write_enable     | csr_index, csr_write_data
//
//  Three register stages: input, product, result. One transfer per cycle in
//  and out while rsp_ready is high; a req transfer passes the input, product
//  and result registers in order, and rsp_valid rises once it reaches result.
//  The 16x16 multiply sits alone between input and product registers.
//  Synchronous reset empties all stages and loads the clamp defaults.
//  A stall on rsp_ready backs up stage by stage; each stage still accepts
//  while the stage after it moves, so bubbles are squeezed out.
//
module six_step_commutation_duty #(
   parameter int DUTY_FRAC_BITS = 15
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [scd_pkg::VOLT_WIDTH-1:0]  req_voltage_command,
   input  logic [scd_pkg::INV_WIDTH-1:0]          req_inverse_bus_voltage,
   input  logic [scd_pkg::HALL_WIDTH-1:0]         req_hall_sector,
   input  logic                                   req_torque_positive,
   // response
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [scd_pkg::DUTY_WIDTH-1:0]         rsp_duty_u,
   output logic [scd_pkg::DUTY_WIDTH-1:0]         rsp_duty_v,
   output logic [scd_pkg::DUTY_WIDTH-1:0]         rsp_duty_w,
   output logic [scd_pkg::MODE_WIDTH-1:0]         rsp_pwm_mode,
   output logic [scd_pkg::PAIR_WIDTH-1:0]         rsp_phase_pair,
   // configuration
   input  logic                                   csr_write_enable,
   input  logic [scd_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [scd_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);
   import scd_pkg::*;

   // clamp registers
   logic [CSR_DATA_WIDTH-1:0] max_duty_ff, max_duty_in;
   logic [CSR_DATA_WIDTH-1:0] min_duty_ff, min_duty_in;

   // input stage
   logic                         a_valid_ff, a_valid_in;
   logic signed [VOLT_WIDTH-1:0] a_volt_ff;
   logic [INV_WIDTH-1:0]         a_inv_ff;
   logic [HALL_WIDTH-1:0]        a_hall_ff;
   logic                         a_torque_ff;

   // product stage
   logic                         b_valid_ff, b_valid_in;
   logic signed [PROD_WIDTH-1:0] b_product_ff, b_product_in;
   logic [HALL_WIDTH-1:0]        b_hall_ff;
   logic                         b_torque_ff;

   // result stage
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DUTY_WIDTH-1:0] duty_u_ff, duty_u_in;
   logic [DUTY_WIDTH-1:0] duty_v_ff, duty_v_in;
   logic [DUTY_WIDTH-1:0] duty_w_ff, duty_w_in;
   logic [MODE_WIDTH-1:0] mode_ff, mode_in;
   logic [PAIR_WIDTH-1:0] pair_ff, pair_in;

   // flow control
   logic                  out_load;
   logic                  b_load;
   logic                  a_load;
   logic signed [PROD_WIDTH:0] product_wide;
   logic [DUTY_WIDTH-1:0] duty;
   commut_type            commut;

   // a stage loads when its downstream slot is free or being vacated
   assign out_load  = b_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign b_load    = a_valid_ff && (!b_valid_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !a_valid_ff || !b_valid_ff || !rsp_valid_ff || rsp_ready;
   assign a_load    = req_valid && req_ready;

   always_comb begin
      max_duty_in = max_duty_ff;
      min_duty_in = min_duty_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_DUTY: max_duty_in = csr_write_data;
            CSR_MIN_DUTY: min_duty_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      a_valid_in   = a_load || (a_valid_ff && !b_load);
      b_valid_in   = b_load || (b_valid_ff && !out_load);
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   // 16b signed x 16b unsigned; result always fits 32 bits signed
   assign product_wide = a_volt_ff * $signed({1'b0, a_inv_ff});
   assign b_product_in = product_wide[PROD_WIDTH-1:0];

   scd_duty #(
      .DUTY_FRAC_BITS (DUTY_FRAC_BITS)
   ) u_duty (
      .product  (b_product_ff),
      .max_duty (max_duty_ff),
      .min_duty (min_duty_ff),
      .duty     (duty)
   );

   scd_sector u_sector (
      .hall_sector     (b_hall_ff),
      .torque_positive (b_torque_ff),
      .commut          (commut)
   );

   // duty goes only to the high-side phase
   always_comb begin
      duty_u_in = (commut.high == PHASE_U) ? duty : '0;
      duty_v_in = (commut.high == PHASE_V) ? duty : '0;
      duty_w_in = (commut.high == PHASE_W) ? duty : '0;
      mode_in   = commut.mode;
      pair_in   = commut.pair;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_duty_ff  <= MAX_DUTY_RESET;
         min_duty_ff  <= MIN_DUTY_RESET;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_duty_ff  <= max_duty_in;
         min_duty_ff  <= min_duty_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (a_load) begin
         a_volt_ff   <= req_voltage_command;
         a_inv_ff    <= req_inverse_bus_voltage;
         a_hall_ff   <= req_hall_sector;
         a_torque_ff <= req_torque_positive;
      end
      if (b_load) begin
         b_product_ff <= b_product_in;
         b_hall_ff    <= a_hall_ff;
         b_torque_ff  <= a_torque_ff;
      end
      if (out_load) begin
         duty_u_ff <= duty_u_in;
         duty_v_ff <= duty_v_in;
         duty_w_ff <= duty_w_in;
         mode_ff   <= mode_in;
         pair_ff   <= pair_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_duty_u     = duty_u_ff;
   assign rsp_duty_v     = duty_v_ff;
   assign rsp_duty_w     = duty_w_ff;
   assign rsp_pwm_mode   = mode_ff;
   assign rsp_phase_pair = pair_ff;

endmodule

@@ rtl/scd_checker.sv @@
// ----------------------------------------------------------------------------
// scd_checker
// Port-level checks for six_step_commutation_duty, bound to the top level.
// ----------------------------------------------------------------------------
module scd_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [scd_pkg::DUTY_WIDTH-1:0]        rsp_duty_u,
   input logic [scd_pkg::DUTY_WIDTH-1:0]        rsp_duty_v,
   input logic [scd_pkg::DUTY_WIDTH-1:0]        rsp_duty_w,
   input logic [scd_pkg::MODE_WIDTH-1:0]        rsp_pwm_mode,
   input logic [scd_pkg::PAIR_WIDTH-1:0]        rsp_phase_pair
);
   import scd_pkg::*;

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase_pair)
         && $stable(rsp_duty_u) && $stable(rsp_duty_v) && $stable(rsp_duty_w))
      else $error("stalled response changed");

   // reset empties the pipeline
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // only the high-side phase carries duty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_duty_u != '0, rsp_duty_v != '0,
                                rsp_duty_w != '0}) <= 1)
      else $error("more than one phase driven");

   // mode and duty placement agree with the phase pair
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_phase_pair == PAIR_UH_VL && rsp_pwm_mode == MODE_UV_W_OFF
              && rsp_duty_v == '0 && rsp_duty_w == '0)
       || (rsp_phase_pair == PAIR_UH_WL && rsp_pwm_mode == MODE_UW_V_OFF
              && rsp_duty_v == '0 && rsp_duty_w == '0)
       || (rsp_phase_pair == PAIR_VH_WL && rsp_pwm_mode == MODE_U_OFF_VW
              && rsp_duty_u == '0 && rsp_duty_w == '0)
       || (rsp_phase_pair == PAIR_VH_UL && rsp_pwm_mode == MODE_UV_W_OFF
              && rsp_duty_u == '0 && rsp_duty_w == '0)
       || (rsp_phase_pair == PAIR_WH_UL && rsp_pwm_mode == MODE_UW_V_OFF
              && rsp_duty_u == '0 && rsp_duty_v == '0)
       || (rsp_phase_pair == PAIR_WH_VL && rsp_pwm_mode == MODE_U_OFF_VW
              && rsp_duty_u == '0 && rsp_duty_v == '0)))
      else $error("phase pair, mode and duties disagree");

endmodule

bind six_step_commutation_duty scd_checker u_scd_checker (.*);

@@ bench/six_step_commutation_duty_tb.sv @@
// ----------------------------------------------------------------------------
// six_step_commutation_duty_tb
// Self-checking bench for the six-step commutation duty block: a directed set
// of corner commands, then random commands under several clamp settings, with
// random idle bursts on the request side and random stalls on the response
// side. Every response transfer is checked field by field against an
// in-order model of the duty math and the sector-to-phase-pair mapping.
// ----------------------------------------------------------------------------
module six_step_commutation_duty_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import scd_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 11;
   localparam int FRAC_SHIFT   = PROD_FRAC - 15;   // Q8.24 -> Q1.15
   localparam int FULL_DUTY    = 1 << 15;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 156;               // ~1250 random commands total
   localparam int CALM_ITEMS   = 80;                // tail of the run without idling
   localparam int MAX_REPORTS  = 10;

   // one response, laid out in port order so a concatenation fills it
   typedef struct packed {
      logic [DUTY_WIDTH-1:0] duty_u;
      logic [DUTY_WIDTH-1:0] duty_v;
      logic [DUTY_WIDTH-1:0] duty_w;
      logic [MODE_WIDTH-1:0] mode;
      logic [PAIR_WIDTH-1:0] pair;
   } phase_duty_type;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts the phase duties for each request transfer and
   // checks response transfers in order.
   // -------------------------------------------------------------------------
   class commutation_scoreboard;
      logic [DUTY_WIDTH-1:0] max_duty;
      logic [DUTY_WIDTH-1:0] min_duty;
      phase_duty_type        pending_duties[$];
      int                    mismatches;

      function new();
         max_duty   = MAX_DUTY_RESET;
         min_duty   = MIN_DUTY_RESET;
         mismatches = 0;
      endfunction

      function void set_limits(input logic [DUTY_WIDTH-1:0] upper,
                               input logic [DUTY_WIDTH-1:0] lower);
         max_duty = upper;
         min_duty = lower;
      endfunction

      function int pending();
         return pending_duties.size();
      endfunction

      function void fail(input string msg);
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("%0t mismatch: %s", $realtime, msg);
         end
      endfunction

      function phase_duty_type commutate(input logic signed [VOLT_WIDTH-1:0] volt,
                                         input logic [INV_WIDTH-1:0]         inv,
                                         input logic [HALL_WIDTH-1:0]        hall,
                                         input logic                         torque);
         longint                product;
         int                    duty;
         int                    limited;
         int                    sector;
         logic [PAIR_WIDTH-1:0] pair;
         phase_type             high;
         phase_duty_type        r;
         // Q8.8 x Q0.16 -> Q8.24, negative gives zero, above one saturates
         product = $signed(volt) * $signed({1'b0, inv});
         if (product <= 0) begin
            duty = 0;
         end else begin
            duty = int'(product >>> FRAC_SHIFT);
            if (duty > FULL_DUTY) duty = FULL_DUTY;
         end
         // max clamp is checked first; with crossed clamps, duties above max get max, the rest min
         if (duty > int'(max_duty)) begin
            limited = int'(max_duty);
         end else if (duty < int'(min_duty)) begin
            limited = int'(min_duty);
         end else begin
            limited = duty;
         end
         // advance two sectors or step back one, wrap into 1..6
         sector = int'(hall) + (torque ? 2 : -1);
         if (sector > NUM_SECTORS) sector -= NUM_SECTORS;
         if (sector < 1) sector += NUM_SECTORS;
         case (sector)
            1:       pair = PAIR_WH_VL;
            2:       pair = PAIR_UH_VL;
            3:       pair = PAIR_UH_WL;
            4:       pair = PAIR_VH_WL;
            5:       pair = PAIR_VH_UL;
            default: pair = PAIR_WH_UL;
         endcase
         case (pair)
            PAIR_UH_VL, PAIR_VH_UL: r.mode = MODE_UV_W_OFF;
            PAIR_UH_WL, PAIR_WH_UL: r.mode = MODE_UW_V_OFF;
            default:                r.mode = MODE_U_OFF_VW;
         endcase
         case (pair)
            PAIR_UH_VL, PAIR_UH_WL: high = PHASE_U;
            PAIR_VH_WL, PAIR_VH_UL: high = PHASE_V;
            default:                high = PHASE_W;
         endcase
         r.pair   = pair;
         r.duty_u = (high == PHASE_U) ? limited[DUTY_WIDTH-1:0] : '0;
         r.duty_v = (high == PHASE_V) ? limited[DUTY_WIDTH-1:0] : '0;
         r.duty_w = (high == PHASE_W) ? limited[DUTY_WIDTH-1:0] : '0;
         return r;
      endfunction

      function void note_command(input logic signed [VOLT_WIDTH-1:0] volt,
                                 input logic [INV_WIDTH-1:0]         inv,
                                 input logic [HALL_WIDTH-1:0]        hall,
                                 input logic                         torque);
         pending_duties.push_back(commutate(volt, inv, hall, torque));
      endfunction

      function void check_result(input phase_duty_type got);
         phase_duty_type want;
         if (pending_duties.size() == 0) begin
            fail($sformatf("response with nothing pending: %p", got));
            return;
         end
         want = pending_duties.pop_front();
         if (got.duty_u !== want.duty_u)
            fail($sformatf("duty_u expected %0d actual %0d", want.duty_u, got.duty_u));
         if (got.duty_v !== want.duty_v)
            fail($sformatf("duty_v expected %0d actual %0d", want.duty_v, got.duty_v));
         if (got.duty_w !== want.duty_w)
            fail($sformatf("duty_w expected %0d actual %0d", want.duty_w, got.duty_w));
         if (got.mode !== want.mode)
            fail($sformatf("pwm_mode expected %0d actual %0d", want.mode, got.mode));
         if (got.pair !== want.pair)
            fail($sformatf("phase_pair expected %0d actual %0d", want.pair, got.pair));
      endfunction

      function void finish_check();
         while (pending_duties.size() != 0) begin
            fail($sformatf("response never arrived: %p", pending_duties.pop_front()));
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT and its signals; every input starts at a known value
   // -------------------------------------------------------------------------
   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic signed [VOLT_WIDTH-1:0] req_voltage_command = '0;
   logic [INV_WIDTH-1:0]         req_inverse_bus_voltage = '0;
   logic [HALL_WIDTH-1:0]        req_hall_sector = '0;
   logic                         req_torque_positive = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [DUTY_WIDTH-1:0]        rsp_duty_u;
   logic [DUTY_WIDTH-1:0]        rsp_duty_v;
   logic [DUTY_WIDTH-1:0]        rsp_duty_w;
   logic [MODE_WIDTH-1:0]        rsp_pwm_mode;
   logic [PAIR_WIDTH-1:0]        rsp_phase_pair;
   logic                         csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index = CSR_MAX_DUTY;
   logic [CSR_DATA_WIDTH-1:0]    csr_write_data = '0;

   // idle bursts on both sides are only allowed while this is set
   bit                           idle_enable = 1'b1;

   commutation_scoreboard        sb;

   six_step_commutation_duty dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_voltage_command     (req_voltage_command),
      .req_inverse_bus_voltage (req_inverse_bus_voltage),
      .req_hall_sector         (req_hall_sector),
      .req_torque_positive     (req_torque_positive),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_duty_u              (rsp_duty_u),
      .rsp_duty_v              (rsp_duty_v),
      .rsp_duty_w              (rsp_duty_w),
      .rsp_pwm_mode            (rsp_pwm_mode),
      .rsp_phase_pair          (rsp_phase_pair),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // -------------------------------------------------------------------------
   // Corner commands. Hall sector and torque come from the entry index, so
   // all sixteen sector/direction combinations (including the out-of-range
   // sectors zero and seven) appear once.
   // -------------------------------------------------------------------------
   logic signed [VOLT_WIDTH-1:0] corner_volt [16] = '{
      16'sh7FFF, 16'sh8000, 16'sd0,     16'sd512,
      16'sd513,  16'sd256,  16'sd1,     -16'sd1,
      16'sh7FFF, 16'sh8000, 16'sd1,     16'sh7FFF,
      16'sh5555, 16'shAAAA, 16'sd100,   16'sd257
   };
   logic [INV_WIDTH-1:0] corner_inv [16] = '{
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000,   // saturate, negative, zero, exactly one
      16'h8000, 16'hFFFF, 16'h0001, 16'hFFFF,   // just over one, just under, tiny > 0
      16'h0000, 16'h0000, 16'hFFFF, 16'h0001,   // zero inverse, small products
      16'hAAAA, 16'h5555, 16'h0200, 16'hFFFF    // bit patterns, mid, over by a little
   };

   // clamp settings per phase: {max_duty, min_duty}; phase 0 runs on reset
   // values and the last phase is picked at random
   logic [DUTY_WIDTH-1:0] phase_max [PHASE_COUNT] = '{
      16'd32768, 16'd24000, 16'd0, 16'd0, 16'd65535, 16'd32768, 16'd65535, 16'd0
   };
   logic [DUTY_WIDTH-1:0] phase_min [PHASE_COUNT] = '{
      16'd0, 16'd2000, 16'd0, 16'd32768, 16'd65535, 16'd32768, 16'd0, 16'd0
   };

   // -------------------------------------------------------------------------
   // Request driver. Valid stays high across back-to-back transfers; a random
   // idle burst drops it before the payload goes out.
   // -------------------------------------------------------------------------
   task automatic send_command(input logic signed [VOLT_WIDTH-1:0] volt,
                               input logic [INV_WIDTH-1:0]         inv,
                               input logic [HALL_WIDTH-1:0]        hall,
                               input logic                         torque);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_voltage_command     <= volt;
      req_inverse_bus_voltage <= inv;
      req_hall_sector         <= hall;
      req_torque_positive     <= torque;
      // values read right after the edge are the ones the DUT sampled
      do @(posedge clock); while (!req_ready);
      sb.note_command(volt, inv, hall, torque);
   endtask

   // Random command, biased toward products that land near full scale and
   // the clamps, with some fully random and some extreme values mixed in.
   task automatic send_random_command();
      logic signed [VOLT_WIDTH-1:0] volt;
      logic [INV_WIDTH-1:0]         inv;
      inv = 16'($urandom);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: volt = 16'($urandom_range(0, 1023));     // duty spans 0..~4x full
         4, 5:       volt = 16'($urandom);
         6:          volt = 16'($urandom) | 16'h8000;         // always negative
         7:          volt = 16'($urandom_range(0, 80));       // small duties, near min clamp
         8: begin
            case ($urandom_range(0, 4))
               0:       volt = 16'sh7FFF;
               1:       volt = 16'sh8000;
               2:       volt = 16'sd0;
               3:       volt = 16'sd1;
               default: volt = -16'sd1;
            endcase
            case ($urandom_range(0, 2))
               0:       inv = 16'h0000;
               1:       inv = 16'hFFFF;
               default: inv = 16'h0001;
            endcase
         end
         default: begin
            volt = 16'($urandom);
            inv  = 16'($urandom_range(0, 255));
         end
      endcase
      send_command(volt, inv, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
   endtask

   // lower valid after the last transfer, then wait for the pipe to empty
   task automatic drain_pipe(input int tail_cycles);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (tail_cycles) @(posedge clock);
   endtask

   // both clamp registers, one per cycle; only called with the pipe empty
   task automatic write_limits(input logic [DUTY_WIDTH-1:0] upper,
                               input logic [DUTY_WIDTH-1:0] lower);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_MAX_DUTY;
      csr_write_data   <= upper;
      @(posedge clock);
      csr_index        <= CSR_MIN_DUTY;
      csr_write_data   <= lower;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_limits(upper, lower);
   endtask

   // -------------------------------------------------------------------------
   // Response side: random stalls while idling is enabled
   // -------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && idle_enable && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // every response transfer goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result({rsp_duty_u, rsp_duty_v, rsp_duty_w, rsp_pwm_mode, rsp_phase_pair});
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [DUTY_WIDTH-1:0] upper;
      logic [DUTY_WIDTH-1:0] lower;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners on the reset clamps
      for (int i = 0; i < 16; i++) begin
         send_command(corner_volt[i], corner_inv[i], 3'(i >> 1), i[0]);
      end
      send_command(16'sd1000, 16'd100, 3'd3, 1'b1);
      send_command(16'sd300, 16'd40000, 3'd6, 1'b0);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p != 0) begin
            drain_pipe(4);
            upper = phase_max[p];
            lower = phase_min[p];
            if (p == PHASE_COUNT - 1) begin
               upper = 16'($urandom_range(1000, FULL_DUTY));
               lower = 16'($urandom_range(0, upper));
            end
            write_limits(upper, lower);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // idling comes and goes in stretches; none near the end
            if (n % 40 == 0) idle_enable = ($urandom_range(0, 3) != 0);
            if (p == PHASE_COUNT - 1 && n >= PHASE_ITEMS - CALM_ITEMS) idle_enable = 1'b0;
            send_random_command();
         end
      end

      drain_pipe(10);
      sb.finish_check();
      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #(4_000_000);
      $display("simulation failed");
      $finish;
   end

endmodule
